FILE: hw/rtl/salc_pkg.sv
// salc_pkg: shared types, constants and helpers for the set-associative lookup
// no dependencies; imported by set_assoc_lru_cache_lookup
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

	localparam int ADDR_W     = 32;
	localparam int SET_COUNT  = 256;
	localparam int NUM_WAYS   = 8;
	localparam int SET_W      = $clog2(SET_COUNT);
	localparam int WAY_W      = 3;
	localparam int WAYS_REG_W = 4;
	localparam int OFS_REG_W  = 5;
	localparam int SETB_REG_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int STAMP_W    = 32;
	localparam int TAG_W      = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_OFFSET = 2'd0,
		CFG_SET_BITS     = 2'd1,
		CFG_WAYS         = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;

	// replacement candidate inside the minimum tree
	typedef struct packed {
		logic               used;
		logic [WAY_W-1:0]   idx;
		logic [STAMP_W-1:0] stamp;
	} cand_t;

	// a holds the lower way numbers, b the higher ones; ties go to b
	function automatic cand_t pick_min(cand_t a, cand_t b);
		cand_t r;
		if (b.used && (!a.used || (b.stamp <= a.stamp))) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_lookup.sv
// set_assoc_lru_cache_lookup: tag store lookup with lru replacement
// depends on salc_pkg
`timescale 1ns / 1ps
`default_nettype none
// Each address transaction runs in three steps: reading the set's row from
// the tag/stamp memory, comparing tags and halving the replacement
// candidates, and finishing the minimum search and writing the row back.
// A new address is taken only in idle, so the next read always sees the row
// written by the previous transaction. The memory has one row per set (256
// rows, all ways side by side); a valid flag per row, cleared by reset, makes
// an unwritten row read as all zero, so no clearing pass is needed after
// reset. The result sits in an output register; the write-back of the next
// transaction waits only while an earlier result has not yet been taken.
// Configuration must be written while idle; the block does not check it.
module set_assoc_lru_cache_lookup (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [salc_pkg::ADDR_W-1:0]      address,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            hit,
	output logic [salc_pkg::WAY_W-1:0]      way
);
	import salc_pkg::*;

	// configuration registers
	logic [OFS_REG_W-1:0]  block_offset_bits_q;
	logic [SETB_REG_W-1:0] set_index_bits_q;
	logic [WAYS_REG_W-1:0] ways_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_offset_bits_q <= '0;
			set_index_bits_q    <= '0;
			ways_in_use_q       <= WAYS_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BLOCK_OFFSET: block_offset_bits_q <= cfg_data[OFS_REG_W-1:0];
				CFG_SET_BITS:     set_index_bits_q    <= cfg_data[SETB_REG_W-1:0];
				CFG_WAYS:         ways_in_use_q       <= cfg_data[WAYS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// control
	state_t state_q;
	logic   accept;
	logic   upd_go;
	logic   out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	// write-back may proceed once the output register is free or emptying
	assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD:  if (upd_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// address decode: set bits clamp to the memory depth, ways clamp to 1..8
	logic [SETB_REG_W-1:0] sbits;
	logic [WAYS_REG_W-1:0] ways_eff;
	logic [ADDR_W-1:0]     block_num;
	logic [SET_W-1:0]      set_mask;
	logic [SET_W-1:0]      set_idx;
	logic [OFS_REG_W:0]    tag_shift;
	logic [TAG_W-1:0]      tag_new;

	always_comb begin
		if (set_index_bits_q > SETB_REG_W'(SET_W)) begin
			sbits = SETB_REG_W'(SET_W);
		end else begin
			sbits = set_index_bits_q;
		end
		if (ways_in_use_q == '0) begin
			ways_eff = WAYS_REG_W'(1);
		end else if (ways_in_use_q > WAYS_REG_W'(NUM_WAYS)) begin
			ways_eff = WAYS_REG_W'(NUM_WAYS);
		end else begin
			ways_eff = ways_in_use_q;
		end
		block_num = address >> block_offset_bits_q;
		set_mask  = SET_W'(({{SET_W{1'b0}}, 1'b1} << sbits) - 1'b1);
		set_idx   = block_num[SET_W-1:0] & set_mask;
		tag_shift = {1'b0, block_offset_bits_q} + (OFS_REG_W+1)'(sbits);
		// shifts of the full width or more leave zero
		tag_new   = TAG_W'(address >> tag_shift);
	end

	// global access counter, bumped once per transaction
	logic [STAMP_W-1:0] counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (accept) begin
			counter_q <= counter_q + 1'b1;
		end
	end

	// stage 1 registers, captured with the transaction
	logic [SET_W-1:0]      set_s1;
	logic [TAG_W-1:0]      tag_s1;
	logic [STAMP_W-1:0]    stamp_s1;
	logic [WAYS_REG_W-1:0] ways_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1   <= set_idx;
			tag_s1   <= tag_new;
			stamp_s1 <= counter_q + 1'b1;
			ways_s1  <= ways_eff;
		end
	end

	// row memory with per-row valid flags
	row_t                 line_mem [SET_COUNT];
	logic [SET_COUNT-1:0] row_valid_q;
	row_t                 rd_row_s1;
	logic                 rd_row_valid_s1;
	row_t                 row_cur;
	row_t                 row_wr;
	logic [WAY_W-1:0]     victim;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= line_mem[set_idx];
		end
		if (upd_go) begin
			line_mem[set_s1] <= row_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q     <= '0;
			rd_row_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				rd_row_valid_s1 <= row_valid_q[set_idx];
			end
			if (upd_go) begin
				row_valid_q[set_s1] <= 1'b1;
			end
		end
	end

	// an unwritten row reads as all lines invalid with zero tag and stamp
	assign row_cur = rd_row_valid_s1 ? rd_row_s1 : '0;

	// compare stage: hit search and first level of the minimum tree
	logic                  hit_c;
	logic [WAY_W-1:0]      hit_way_c;
	cand_t [NUM_WAYS-1:0]  leaf;
	cand_t [NUM_WAYS/2-1:0] half_c;

	always_comb begin
		hit_c     = 1'b0;
		hit_way_c = '0;
		// walk downwards so the lowest matching way wins
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if ((WAYS_REG_W'(w) < ways_s1) && row_cur[w].valid &&
			    (row_cur[w].tag == tag_s1)) begin
				hit_c     = 1'b1;
				hit_way_c = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			leaf[w].used  = (WAYS_REG_W'(w) < ways_s1);
			leaf[w].idx   = WAY_W'(w);
			leaf[w].stamp = row_cur[w].stamp;
		end
		for (int p = 0; p < NUM_WAYS / 2; p++) begin
			half_c[p] = pick_min(leaf[2*p], leaf[2*p+1]);
		end
	end

	logic                   hit_s2;
	logic [WAY_W-1:0]       hit_way_s2;
	cand_t [NUM_WAYS/2-1:0] half_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			hit_s2     <= hit_c;
			hit_way_s2 <= hit_way_c;
			half_s2    <= half_c;
		end
	end

	// update stage: rest of the tree, victim select and row write-back
	cand_t best;

	always_comb begin
		best   = pick_min(pick_min(half_s2[0], half_s2[1]),
		                  pick_min(half_s2[2], half_s2[3]));
		victim = hit_s2 ? hit_way_s2 : best.idx;
		row_wr = row_cur;
		row_wr[victim].valid = 1'b1;
		row_wr[victim].tag   = tag_s1;
		row_wr[victim].stamp = stamp_s1;
	end

	// output register
	logic             hit_q;
	logic [WAY_W-1:0] way_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			hit_q <= hit_s2;
			way_q <= victim;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign way       = way_q;

`ifndef SYNTH
	// counter moves by exactly one per accepted transaction
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (counter_q == $past(counter_q) + 1'b1))
		else $error("access counter did not advance on transaction");

	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(counter_q))
		else $error("access counter moved without a transaction");

	// a write-back always leaves a result waiting and the row marked valid
	a_wb_result: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> (out_valid_q && row_valid_q[$past(set_s1)]))
		else $error("write-back without result or row valid");

	// no new address while a lookup is in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!in_ready ##1 !in_ready))
		else $error("address taken during a lookup");
`endif

endmodule
`default_nettype wire
